// ===== rtl/dpf_pkg.sv =====
// shared types and constants of the dpd pair force unit
`default_nettype none
package dpf_pkg;

  // one particle pair request
  typedef struct packed {
    logic [47:0] pos_i;
    logic [47:0] pos_j;
    logic [47:0] vel_i;
    logic [47:0] vel_j;
    logic        type_i;
    logic        type_j;
    logic [15:0] rand_u;
  } dpf_in_t;

  // force on particle i plus status
  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         pair_status;
  } dpf_out_t;

  // register file contents
  typedef struct packed {
    logic [3:0][15:0] strength;
    logic [15:0]      drag_gain;
    logic [15:0]      noise_gain;
    logic [15:0]      box_size;
    logic [15:0]      cutoff;
  } dpf_cfg_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_STR_00, REG_STR_01, REG_STR_10, REG_STR_11,
    REG_DRAG, REG_NOISE, REG_BOX, REG_CUTOFF
  } dpf_reg_e;

  // pair status codes
  typedef enum logic [1:0] {
    ST_OK, ST_FAR, ST_COINC, ST_SAT
  } dpf_status_e;

  localparam int AXES      = 3;
  localparam int SQ_STEPS  = 27;  // one root bit per stage
  localparam int ROOT_W    = 27;
  localparam int SQ_REM_W  = 28;
  localparam int DIV_STEPS = 17;  // one quotient bit per stage
  localparam int Q_W       = 17;
  localparam int DIV_W     = 27;
  localparam int LANES     = 4;   // w quotient plus three unit vector axes

  // per-pair data that rides along the long arithmetic stages
  typedef struct packed {
    logic [2:0][16:0] dv;     // velocity difference, signed Q4.12
    logic [2:0]       neg;    // separation sign
    logic [2:0][15:0] mag;    // separation magnitude, Q.11
    logic [15:0]      a;      // conservative strength
    logic [15:0]      rand_u;
    logic [1:0]       status;
  } dpf_side_t;

endpackage
`default_nettype wire

// ===== rtl/dpf_front.sv =====
// separation, squared distance and cutoff test (three stages)
`default_nettype none
module dpf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  dpf_pkg::dpf_in_t   in_data,
  input  dpf_pkg::dpf_cfg_t  cfg,
  output logic               v_o,
  output logic [31:0]        r2_o,
  output dpf_pkg::dpf_side_t side_o
);
  import dpf_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic signed [16:0] d_nxt  [AXES];
  logic signed [16:0] dv_nxt [AXES];
  logic signed [16:0] d1_r   [AXES];
  logic signed [16:0] dv1_r  [AXES];
  logic [15:0]        a1_r, rand1_r;
  logic [32:0]        sq2_r  [AXES];
  logic [31:0]        c2_r;
  dpf_side_t          side2_r, side3_r;
  dpf_side_t          side3_nxt;
  logic [31:0]        r2_3_r;
  logic [33:0]        r2_sum;
  logic [1:0]         st_nxt;

  // minimum image difference and velocity difference
  always_comb begin
    logic signed [16:0] diff;
    logic signed [16:0] lext;
    logic signed [17:0] twice;
    logic signed [17:0] lsz;
    lext = signed'({1'b0, cfg.box_size});
    lsz  = signed'({2'b00, cfg.box_size});
    for (int k = 0; k < AXES; k++) begin
      diff  = signed'({1'b0, in_data.pos_i[16*k +: 16]})
            - signed'({1'b0, in_data.pos_j[16*k +: 16]});
      twice = {diff, 1'b0};
      if (twice > lsz) begin
        d_nxt[k] = diff - lext;
      end else if (twice < -lsz) begin
        d_nxt[k] = diff + lext;
      end else begin
        d_nxt[k] = diff;
      end
      dv_nxt[k] = signed'({in_data.vel_i[16*k+15], in_data.vel_i[16*k +: 16]})
                - signed'({in_data.vel_j[16*k+15], in_data.vel_j[16*k +: 16]});
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: differences and strength lookup
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        d1_r[k]  <= d_nxt[k];
        dv1_r[k] <= dv_nxt[k];
      end
      a1_r    <= cfg.strength[{in_data.type_i, in_data.type_j}];
      rand1_r <= in_data.rand_u;
    end
  end

  // stage 2: squares and cutoff squared
  always_ff @(posedge clk) begin
    logic signed [33:0] sq;
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        sq               = d1_r[k] * d1_r[k];
        sq2_r[k]         <= sq[32:0];
        side2_r.dv[k]    <= dv1_r[k];
        side2_r.neg[k]   <= d1_r[k][16];
        side2_r.mag[k]   <= d1_r[k][16] ? 16'(-d1_r[k]) : d1_r[k][15:0];
      end
      c2_r           <= cfg.cutoff * cfg.cutoff;
      side2_r.a      <= a1_r;
      side2_r.rand_u <= rand1_r;
      side2_r.status <= ST_OK;
    end
  end

  // stage 3: distance squared and pair classification
  assign r2_sum = {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]} + {1'b0, sq2_r[2]};

  always_comb begin
    if (r2_sum == '0) begin
      st_nxt = ST_COINC;
    end else if (r2_sum > {2'b00, c2_r}) begin
      st_nxt = ST_FAR;
    end else begin
      st_nxt = ST_OK;
    end
  end

  // side data with the pair class filled in
  always_comb begin
    side3_nxt        = side2_r;
    side3_nxt.status = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_3_r  <= r2_sum[31:0];
      side3_r <= side3_nxt;
    end
  end

  assign v_o    = v3_r;
  assign r2_o   = r2_3_r;
  assign side_o = side3_r;

endmodule
`default_nettype wire

// ===== rtl/dpf_sqrt.sv =====
// pipelined square root of r2 scaled to Q.22, one root bit per stage
`default_nettype none
module dpf_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_i,
  input  logic [31:0]            r2_i,
  input  dpf_pkg::dpf_side_t     side_i,
  output logic                   v_o,
  output logic [dpf_pkg::ROOT_W-1:0] root_o,
  output dpf_pkg::dpf_side_t     side_o
);
  import dpf_pkg::*;

  logic                v_r    [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0]   root_r [SQ_STEPS];
  logic [31:0]         r2_r   [SQ_STEPS];
  dpf_side_t           side_r [SQ_STEPS];

  logic                v_in    [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_in  [SQ_STEPS];
  logic [ROOT_W-1:0]   root_in [SQ_STEPS];
  logic [31:0]         r2_in   [SQ_STEPS];
  dpf_side_t           side_in [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_nxt [SQ_STEPS];
  logic [ROOT_W-1:0]   root_nxt[SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    // stage input: pipeline head or previous stage
    if (k == 0) begin : g_head
      assign v_in[k]    = v_i;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign r2_in[k]   = r2_i;
      assign side_in[k] = side_i;
    end else begin : g_body
      assign v_in[k]    = v_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign r2_in[k]   = r2_r[k-1];
      assign side_in[k] = side_r[k-1];
    end

    // one restoring root step on the next bit pair
    always_comb begin
      logic [53:0]         rad;
      logic [SQ_REM_W+1:0] acc;
      logic [SQ_REM_W+1:0] trial;
      rad   = {r2_in[k], 22'd0};
      acc   = {rem_in[k], rad[53-2*k -: 2]};
      trial = {1'b0, root_in[k], 2'b01};
      if (acc >= trial) begin
        rem_nxt[k]  = SQ_REM_W'(acc - trial);
        root_nxt[k] = {root_in[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = acc[SQ_REM_W-1:0];
        root_nxt[k] = {root_in[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        r2_r[k]   <= r2_in[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign v_o    = v_r[SQ_STEPS-1];
  assign root_o = root_r[SQ_STEPS-1];
  assign side_o = side_r[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/dpf_div.sv =====
// four-lane pipelined divider: w quotient and unit vector, one bit per stage
`default_nettype none
module dpf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_i,
  input  logic [dpf_pkg::ROOT_W-1:0]   root_i,
  input  dpf_pkg::dpf_side_t           side_i,
  input  dpf_pkg::dpf_cfg_t            cfg,
  output logic                         v_o,
  output logic [dpf_pkg::LANES-1:0][dpf_pkg::Q_W-1:0] q_o,
  output dpf_pkg::dpf_side_t           side_o
);
  import dpf_pkg::*;

  typedef logic [LANES-1:0][DIV_W-1:0] lane_rem_t;
  typedef logic [LANES-1:0][Q_W-1:0]   lane_q_t;

  logic        v_r    [DIV_STEPS];
  lane_rem_t   rem_r  [DIV_STEPS];
  lane_q_t     lo_r   [DIV_STEPS];
  lane_q_t     q_r    [DIV_STEPS];
  logic [ROOT_W-1:0] root_r [DIV_STEPS];
  dpf_side_t   side_r [DIV_STEPS];

  logic        v_in    [DIV_STEPS];
  lane_rem_t   rem_in  [DIV_STEPS];
  lane_q_t     lo_in   [DIV_STEPS];
  lane_q_t     q_in    [DIV_STEPS];
  logic [ROOT_W-1:0] root_in [DIV_STEPS];
  dpf_side_t   side_in [DIV_STEPS];
  lane_rem_t   rem_nxt [DIV_STEPS];
  lane_q_t     q_nxt   [DIV_STEPS];

  lane_rem_t   rem_init;
  lane_q_t     lo_init;

  // numerators: root << 16 for w, magnitude << 27 for each axis;
  // the upper quotient bits are known zero, so the top part starts as remainder
  always_comb begin
    rem_init[0] = {1'b0, root_i[ROOT_W-1:1]};
    lo_init[0]  = {root_i[0], 16'd0};
    for (int k = 0; k < AXES; k++) begin
      rem_init[k+1] = {1'b0, side_i.mag[k], 10'd0};
      lo_init[k+1]  = '0;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign v_in[s]    = v_i;
      assign rem_in[s]  = rem_init;
      assign lo_in[s]   = lo_init;
      assign q_in[s]    = '0;
      assign root_in[s] = root_i;
      assign side_in[s] = side_i;
    end else begin : g_body
      assign v_in[s]    = v_r[s-1];
      assign rem_in[s]  = rem_r[s-1];
      assign lo_in[s]   = lo_r[s-1];
      assign q_in[s]    = q_r[s-1];
      assign root_in[s] = root_r[s-1];
      assign side_in[s] = side_r[s-1];
    end

    // one restoring division step in every lane
    always_comb begin
      logic [DIV_W:0]   acc;
      logic [DIV_W-1:0] dvs;
      for (int l = 0; l < LANES; l++) begin
        dvs = (l == 0) ? {cfg.cutoff, 11'd0} : root_in[s];
        acc = {rem_in[s][l], lo_in[s][l][Q_W-1-s]};
        if (acc >= {1'b0, dvs}) begin
          rem_nxt[s][l] = DIV_W'(acc - {1'b0, dvs});
          q_nxt[s][l]   = {q_in[s][l][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = acc[DIV_W-1:0];
          q_nxt[s][l]   = {q_in[s][l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt[s];
        lo_r[s]   <= lo_in[s];
        q_r[s]    <= q_nxt[s];
        root_r[s] <= root_in[s];
        side_r[s] <= side_in[s];
      end
    end
  end

  assign v_o    = v_r[DIV_STEPS-1];
  assign q_o    = q_r[DIV_STEPS-1];
  assign side_o = side_r[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/dpf_back.sv =====
// force terms, products and output register (five stages)
`default_nettype none
module dpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_i,
  input  logic [dpf_pkg::LANES-1:0][dpf_pkg::Q_W-1:0] q_i,
  input  dpf_pkg::dpf_side_t  side_i,
  input  dpf_pkg::dpf_cfg_t   cfg,
  output logic                out_valid,
  output dpf_pkg::dpf_out_t   out_data
);
  import dpf_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [Q_W-1:0]     w_c;
  logic signed [17:0] e_c   [AXES];

  // stage 1
  logic signed [17:0] e1_r  [AXES];
  logic signed [34:0] pev_r [AXES];
  logic [32:0]        consp_r;
  logic [32:0]        ww_r;
  logic [32:0]        np_r;
  logic [15:0]        rand1_r;
  logic [1:0]         st1_r;
  // stage 2
  logic signed [17:0] e2_r  [AXES];
  logic signed [24:0] ev_r;
  logic [24:0]        cons2_r;
  logic [32:0]        d1_r;
  logic [32:0]        n2_r;
  logic [1:0]         st2_r;
  logic signed [36:0] ev_sum;
  // stage 3
  logic signed [17:0] e3_r  [AXES];
  logic signed [42:0] dprod_r;
  logic [24:0]        cons3_r;
  logic [16:0]        noise3_r;
  logic [1:0]         st3_r;
  // stage 4
  logic signed [43:0] pc_r  [AXES];
  logic signed [44:0] pd_r  [AXES];
  logic signed [35:0] pn_r  [AXES];
  logic [1:0]         st4_r;
  logic signed [26:0] drag_c;
  // stage 5
  logic signed [31:0] t_c   [AXES];
  dpf_out_t           out_r;

  // weight w = 1 - r/cutoff, floored at zero
  assign w_c = q_i[0][Q_W-1] ? '0 : ({1'b1, 16'd0} - q_i[0]);

  // signed unit vector components
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      e_c[k] = side_i.neg[k] ? -signed'({1'b0, q_i[k+1]}) : signed'({1'b0, q_i[k+1]});
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: e . dv products and weight products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        e1_r[k]  <= e_c[k];
        pev_r[k] <= e_c[k] * signed'(side_i.dv[k]);
      end
      consp_r <= side_i.a * w_c;
      ww_r    <= w_c * w_c;
      np_r    <= cfg.noise_gain * w_c;
      rand1_r <= side_i.rand_u;
      st1_r   <= side_i.status;
    end
  end

  // stage 2: relative velocity along e, drag and noise scaling
  assign ev_sum = 37'(pev_r[0]) + 37'(pev_r[1]) + 37'(pev_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      e2_r    <= e1_r;
      ev_r    <= 25'(ev_sum >>> 12);
      cons2_r <= consp_r[32:8];
      d1_r    <= cfg.drag_gain * ww_r[32:16];
      n2_r    <= np_r[32:16] * rand1_r;
      st2_r   <= st1_r;
    end
  end

  // stage 3: drag magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      e3_r     <= e2_r;
      dprod_r  <= signed'({1'b0, d1_r[32:16]}) * ev_r;
      cons3_r  <= cons2_r;
      noise3_r <= n2_r[32:16];
      st3_r    <= st2_r;
    end
  end

  // stage 4: project each term on e
  assign drag_c = 27'(dprod_r >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        pc_r[k] <= signed'({1'b0, cons3_r}) * e3_r[k];
        pd_r[k] <= drag_c * e3_r[k];
        pn_r[k] <= signed'({1'b0, noise3_r}) * e3_r[k];
      end
      st4_r <= st3_r;
    end
  end

  // stage 5: sum terms; the sum stays well inside 32 bits
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      t_c[k] = 32'(pc_r[k] >>> 16) - 32'(pd_r[k] >>> 16) + 32'(pn_r[k] >>> 16);
    end
  end

  // output register; far and coincident pairs give zero force
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.pair_status <= st4_r;
      if (st4_r != ST_OK) begin
        out_r.force_x <= '0;
        out_r.force_y <= '0;
        out_r.force_z <= '0;
      end else begin
        out_r.force_x <= t_c[0];
        out_r.force_y <= t_c[1];
        out_r.force_z <= t_c[2];
      end
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/dpd_pair_force_unit.sv =====
// top level of the dpd pair force unit
//
//  port group   dir   handshake            payload
//  in_*         in    in_valid / in_stall  dpf_in_t pair request
//  out_*        out   out_valid / out_stall dpf_out_t force and status
//  cfg_*        in    cfg_valid / cfg_ready 3-bit register index, 16-bit data
//
// One pair request per cycle while no finished result is held by out_stall; 3 front stages, 27 root
// stages (one root bit each), 17 divider stages (one quotient bit each, four
// lanes) and 5 product/output stages.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module dpd_pair_force_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dpf_pkg::dpf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dpf_pkg::dpf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import dpf_pkg::*;

  dpf_cfg_t          cfg_r;
  logic              en;
  logic              f_v, s_v, d_v;
  logic [31:0]       f_r2;
  logic [ROOT_W-1:0] s_root;
  logic [LANES-1:0][Q_W-1:0] d_q;
  dpf_side_t         f_side, s_side, d_side;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strength[0] <= 16'd64;
      cfg_r.strength[1] <= 16'd1024;
      cfg_r.strength[2] <= 16'd1024;
      cfg_r.strength[3] <= 16'd2048;
      cfg_r.drag_gain   <= 16'd65405;
      cfg_r.noise_gain  <= 16'd655;
      cfg_r.box_size    <= 16'd40960;
      cfg_r.cutoff      <= 16'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dpf_reg_e'(cfg_index))
        REG_STR_00: cfg_r.strength[0] <= cfg_data;
        REG_STR_01: cfg_r.strength[1] <= cfg_data;
        REG_STR_10: cfg_r.strength[2] <= cfg_data;
        REG_STR_11: cfg_r.strength[3] <= cfg_data;
        REG_DRAG:   cfg_r.drag_gain   <= cfg_data;
        REG_NOISE:  cfg_r.noise_gain  <= cfg_data;
        REG_BOX:    cfg_r.box_size    <= cfg_data;
        REG_CUTOFF: cfg_r.cutoff      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  dpf_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .v_i(in_valid && !in_stall), .in_data(in_data), .cfg(cfg_r),
    .v_o(f_v), .r2_o(f_r2), .side_o(f_side)
  );

  dpf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .v_i(f_v), .r2_i(f_r2), .side_i(f_side),
    .v_o(s_v), .root_o(s_root), .side_o(s_side)
  );

  dpf_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .v_i(s_v), .root_i(s_root), .side_i(s_side), .cfg(cfg_r),
    .v_o(d_v), .q_o(d_q), .side_o(d_side)
  );

  dpf_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .v_i(d_v), .q_i(d_q), .side_i(d_side), .cfg(cfg_r),
    .out_valid(out_valid), .out_data(out_data)
  );

`ifndef SYNTHESIS
  // far and coincident pairs carry zero force
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pair_status == ST_FAR || out_data.pair_status == ST_COINC)
    |-> (out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0))
    else $error("nonzero force on far or coincident pair");

  // input is only held back by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench of the dpd pair force unit
`timescale 1ns / 1ps
module testbench;
  import dpf_pkg::*;

  localparam int LATENCY = 52;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dpf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  dpf_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dpf_cfg_t model_cfg;
  dpf_out_t expected_forces[$];
  int errors = 0;
  int pairs_sent = 0;
  int forces_seen = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  dpd_pair_force_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d forces pending", cycles, expected_forces.size());
      $display("simulation failed");
      $finish;
    end
  end

  // integer square root, floor
  function automatic longint root_floor(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // total force on particle i for one pair
  function automatic dpf_out_t pair_force(dpf_in_t p, dpf_cfg_t c);
    longint d[3], dv[3], e[3];
    longint box, r2, c2, r22, q, w, mag, u, ev, a, cons, drag, noise, t;
    logic signed [15:0] vi, vj;
    dpf_out_t res;
    box = c.box_size;
    r2 = 0;
    ev = 0;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'(p.pos_i[16*k +: 16]) - longint'(p.pos_j[16*k +: 16]);
      if (2 * d[k] > box) d[k] = d[k] - box;
      else if (2 * d[k] < -box) d[k] = d[k] + box;
      vi = p.vel_i[16*k +: 16];
      vj = p.vel_j[16*k +: 16];
      dv[k] = longint'(vi) - longint'(vj);
      r2 = r2 + d[k] * d[k];
    end
    c2 = longint'(c.cutoff) * longint'(c.cutoff);
    // coincident first, then cutoff
    if (r2 == 0) begin
      res.pair_status = ST_COINC;
      return res;
    end
    if (r2 > c2) begin
      res.pair_status = ST_FAR;
      return res;
    end
    r22 = root_floor(r2 << 22);
    q = (r22 << 16) / (longint'(c.cutoff) << 11);
    w = (q >= 65536) ? 0 : 65536 - q;
    for (int k = 0; k < 3; k++) begin
      mag = (d[k] < 0) ? -d[k] : d[k];
      u = (mag << 27) / r22;
      e[k] = (d[k] < 0) ? -u : u;
      ev = ev + e[k] * dv[k];
    end
    ev = ev >>> 12;
    a = c.strength[{p.type_i, p.type_j}];
    cons = (a * w) >>> 8;
    drag = (longint'(c.drag_gain) * ((w * w) >> 16)) >> 16;
    drag = (drag * ev) >>> 16;
    noise = (longint'(c.noise_gain) * w) >> 16;
    noise = (noise * longint'(p.rand_u)) >> 16;
    res.pair_status = ST_OK;
    for (int k = 0; k < 3; k++) begin
      t = ((cons * e[k]) >>> 16) - ((drag * e[k]) >>> 16) + ((noise * e[k]) >>> 16);
      if (t > 64'sd2147483647) begin
        t = 64'sd2147483647;
        res.pair_status = ST_SAT;
      end else if (t < -64'sd2147483648) begin
        t = -64'sd2147483648;
        res.pair_status = ST_SAT;
      end
      case (k)
        0: res.force_x = t[31:0];
        1: res.force_y = t[31:0];
        default: res.force_z = t[31:0];
      endcase
    end
    return res;
  endfunction

  // result checker
  initial begin
    dpf_out_t exp_f;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        forces_seen++;
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          exp_f = expected_forces.pop_front();
          if (out_data.force_x !== exp_f.force_x) begin
            $display("%0t: force_x expected %0d actual %0d", $time, exp_f.force_x,
                     out_data.force_x);
            errors++;
          end
          if (out_data.force_y !== exp_f.force_y) begin
            $display("%0t: force_y expected %0d actual %0d", $time, exp_f.force_y,
                     out_data.force_y);
            errors++;
          end
          if (out_data.force_z !== exp_f.force_z) begin
            $display("%0t: force_z expected %0d actual %0d", $time, exp_f.force_z,
                     out_data.force_z);
            errors++;
          end
          if (out_data.pair_status !== exp_f.pair_status) begin
            $display("%0t: pair_status expected %0d actual %0d", $time,
                     exp_f.pair_status, out_data.pair_status);
            errors++;
          end
        end
      end
    end
  end

  // result receiver with random stalls and one long hold
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // send one pair request, predict its force on acceptance
  task automatic send_pair(dpf_in_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    expected_forces.push_back(pair_force(p, model_cfg));
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(dpf_reg_e idx, logic [15:0] value);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STR_00: model_cfg.strength[0] = value;
      REG_STR_01: model_cfg.strength[1] = value;
      REG_STR_10: model_cfg.strength[2] = value;
      REG_STR_11: model_cfg.strength[3] = value;
      REG_DRAG:   model_cfg.drag_gain = value;
      REG_NOISE:  model_cfg.noise_gain = value;
      REG_BOX:    model_cfg.box_size = value;
      REG_CUTOFF: model_cfg.cutoff = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] s00, logic [15:0] s01, logic [15:0] s10,
                            logic [15:0] s11, logic [15:0] drag, logic [15:0] noise,
                            logic [15:0] box, logic [15:0] cut);
    write_reg(REG_STR_00, s00);
    write_reg(REG_STR_01, s01);
    write_reg(REG_STR_10, s10);
    write_reg(REG_STR_11, s11);
    write_reg(REG_DRAG, drag);
    write_reg(REG_NOISE, noise);
    write_reg(REG_BOX, box);
    write_reg(REG_CUTOFF, cut);
    cfg_valid <= 1'b0;
  endtask

  // wait until every force is back, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_forces.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // pair with random content; near pairs sit within the cutoff, minimum image applied
  function automatic dpf_in_t random_pair(bit near);
    dpf_in_t p;
    int base, off, half, boxv;
    p.vel_i = 48'({$urandom, $urandom});
    p.vel_j = 48'({$urandom, $urandom});
    p.type_i = 1'($urandom_range(0, 1));
    p.type_j = 1'($urandom_range(0, 1));
    p.rand_u = 16'($urandom);
    p.pos_i = 48'({$urandom, $urandom});
    p.pos_j = 48'({$urandom, $urandom});
    if (near) begin
      boxv = (model_cfg.box_size == 0) ? 1 : int'(model_cfg.box_size);
      half = int'(model_cfg.cutoff) / 2;
      for (int k = 0; k < 3; k++) begin
        base = $urandom_range(0, boxv - 1);
        off = int'($urandom_range(0, 2 * half)) - half;
        if (base - off < 0) off = off - boxv;
        else if (base - off >= boxv) off = off + boxv;
        p.pos_i[16*k +: 16] = 16'(base);
        p.pos_j[16*k +: 16] = 16'(base - off);
      end
    end
    return p;
  endfunction

  task automatic random_pairs(int count);
    for (int i = 0; i < count; i++)
      send_pair(random_pair($urandom_range(0, 9) != 0));
  endtask

  // extremes and special cases at reset settings
  task automatic test_directed();
    dpf_in_t p;
    p = '0;
    send_pair(p);                                   // coincident
    p.pos_i = {16'd0, 16'd0, 16'd4096};
    send_pair(p);                                   // beyond cutoff
    p.pos_i = {16'd0, 16'd0, 16'd2048};
    send_pair(p);                                   // exactly at cutoff
    for (int k = 0; k < 3; k++) begin
      p = '0;
      p.pos_i[16*k +: 16] = 16'd700;
      p.type_i = k[0];
      p.type_j = k[1];
      p.vel_i = {3{16'h7fff}};
      p.vel_j = {3{16'h8000}};
      p.rand_u = 16'hffff;
      send_pair(p);                                 // one axis, extreme velocities
    end
    p = '0;
    p.pos_i = {16'd100, 16'd200, 16'd40900};
    p.pos_j = {16'd150, 16'd100, 16'd10};
    p.type_i = 1'b1;
    p.type_j = 1'b1;
    p.vel_i = {3{16'h8000}};
    p.vel_j = {3{16'h7fff}};
    send_pair(p);                                   // wraps across the box edge
    p.pos_j = {16'd100, 16'd200, 16'd40900};
    p.pos_i = {16'd150, 16'd100, 16'd10};
    send_pair(p);                                   // the other direction
    p = '0;
    p.pos_i = {16'd1, 16'd0, 16'd0};
    p.rand_u = 16'hffff;
    send_pair(p);                                   // smallest separation
    p.pos_i = {48{1'b1}};
    p.pos_j = {48{1'b1}};
    send_pair(p);                                   // coincident at field top
    p.pos_j = '0;
    p.vel_i = {48{1'b1}};
    p.vel_j = {48{1'b1}};
    send_pair(p);                                   // far corner outside the box
    drain();
  endtask

  // register extremes and one random setting, each followed by a burst of pairs, then the reset settings again
  task automatic test_config_sweep();
    set_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
               16'hffff, 16'hffff);
    random_pairs(60);
    drain();
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
               16'h0001, 16'h0001);
    random_pairs(30);
    drain();
    set_config(16'h0001, 16'h8000, 16'h00ff, 16'h7fff, 16'h0001, 16'hffff,
               16'd4096, 16'd4095);
    random_pairs(60);
    drain();
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    random_pairs(60);
    drain();
    set_config(16'd64, 16'd1024, 16'd1024, 16'd2048, 16'd65405, 16'd655,
               16'd40960, 16'd2048);
  endtask

  // bulk random pairs with idle and idle-free stretches
  task automatic test_random_stream();
    for (int blk = 0; blk < 8; blk++) begin
      no_idle = (blk % 3 == 2);
      random_pairs(70);
    end
    no_idle = 1'b0;
    drain();
  endtask

  // receiver holds off while pairs keep coming
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_request = 1'b1;
    random_pairs(120);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    model_cfg.strength[0] = 16'd64;
    model_cfg.strength[1] = 16'd1024;
    model_cfg.strength[2] = 16'd1024;
    model_cfg.strength[3] = 16'd2048;
    model_cfg.drag_gain = 16'd65405;
    model_cfg.noise_gain = 16'd655;
    model_cfg.box_size = 16'd40960;
    model_cfg.cutoff = 16'd2048;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_random_stream();
    test_backpressure();
    $display("covered %0d pair requests and %0d results over several register settings,",
             pairs_sent, forces_seen);
    $display("including a long result hold-off, in %0d cycles", cycles);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
